### hdl/fused_pitch_roll_to_quaternion_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the tilt quaternion block
// Shared property forms for the port checker.
// ----------------------------------------------------------------------------
`ifndef FUSED_PITCH_ROLL_TO_QUATERNION_DEFINES_SVH
`define FUSED_PITCH_ROLL_TO_QUATERNION_DEFINES_SVH

// same-cycle implication
`define FPQ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fpq check failed");

// next-cycle implication
`define FPQ_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fpq check failed");

`endif

### hdl/fpq_pkg.sv
// ----------------------------------------------------------------------------
// fpq_pkg
// Constants, tables and helpers for the tilt quaternion pipeline.
// ----------------------------------------------------------------------------
package fpq_pkg;

    localparam int CORDIC_STAGES = 16;   // 8..24
    localparam int SQ_STAGES     = 31;   // one root bit per stage, 62-bit radicand
    localparam int DIV_BITS      = 17;   // quotient bits 16..0

    localparam logic signed [32:0] ANG_PI      = 33'sd1686629713;
    localparam logic signed [32:0] ANG_HALF_PI = 33'sd843314857;
    localparam logic signed [31:0] CORDIC_GAIN = 32'sd326016437;
    localparam logic [15:0]        Q14_MAX     = 16'd16384;

    typedef struct packed {
        logic [30:0] mag_r;
        logic [30:0] mag_p;
        logic        neg_r;
        logic        neg_p;
        logic        sat;
        logic [30:0] root_r;
        logic [15:0] w;
    } sb_t;

    // atan(2^-i) in Q29
    function automatic logic signed [31:0] atan_q29(input int unsigned i);
        logic signed [31:0] v;
        unique case (i)
            0:  v = 32'sd421657428;
            1:  v = 32'sd248918915;
            2:  v = 32'sd131521918;
            3:  v = 32'sd66762579;
            4:  v = 32'sd33510843;
            5:  v = 32'sd16771758;
            6:  v = 32'sd8387925;
            7:  v = 32'sd4194219;
            8:  v = 32'sd2097141;
            9:  v = 32'sd1048575;
            10: v = 32'sd524288;
            11: v = 32'sd262144;
            12: v = 32'sd131072;
            13: v = 32'sd65536;
            14: v = 32'sd32768;
            15: v = 32'sd16384;
            16: v = 32'sd8192;
            17: v = 32'sd4096;
            18: v = 32'sd2048;
            19: v = 32'sd1024;
            20: v = 32'sd512;
            21: v = 32'sd256;
            22: v = 32'sd128;
            23: v = 32'sd64;
            default: v = 32'sd0;
        endcase
        return v;
    endfunction

    // Q3.13 angle to Q29, folded into [-pi/2, pi/2]
    function automatic logic signed [31:0] fold_angle(input logic signed [15:0] a);
        logic signed [32:0] s;
        logic signed [32:0] r;
        s = {a[15], a, 16'h0000};
        if (s > ANG_HALF_PI)
            r = ANG_PI - s;
        else if (s < -ANG_HALF_PI)
            r = -ANG_PI - s;
        else
            r = s;
        return r[31:0];
    endfunction

endpackage

### hdl/fpq_isqrt.sv
// ----------------------------------------------------------------------------
// fpq_isqrt
// Pipelined floor square root of a 62-bit radicand, one root bit per stage.
// ----------------------------------------------------------------------------
module fpq_isqrt
(
    input  logic        clk,
    input  logic        en,
    input  logic [61:0] rad,
    output logic [30:0] root
);
    import fpq_pkg::*;

    logic [61:0] v_reg [SQ_STAGES];
    logic [61:0] r_reg [SQ_STAGES];

    for (genvar k = 0; k < SQ_STAGES; k++) begin : g_stage
        localparam int BP = 2 * (SQ_STAGES - 1 - k);
        logic [61:0] v_in;
        logic [61:0] r_in;
        logic [61:0] t;
        logic [61:0] v_next;
        logic [61:0] r_next;

        if (k == 0) begin : g_first
            assign v_in = rad;
            assign r_in = '0;
        end else begin : g_rest
            assign v_in = v_reg[k-1];
            assign r_in = r_reg[k-1];
        end

        always_comb
        begin
            t = r_in + (62'd1 << BP);
            if (v_in >= t)
            begin
                v_next = v_in - t;
                r_next = (r_in >> 1) + (62'd1 << BP);
            end
            else
            begin
                v_next = v_in;
                r_next = r_in >> 1;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                v_reg[k] <= v_next;
                r_reg[k] <= r_next;
            end
        end
    end

    assign root = r_reg[SQ_STAGES-1][30:0];

endmodule

### hdl/fused_pitch_roll_to_quaternion.sv
// ----------------------------------------------------------------------------
// fused_pitch_roll_to_quaternion
// Roll and pitch (Q3.13) to the unit tilt quaternion w, x, y (Q1.14).
// ----------------------------------------------------------------------------
// One beat in gives one beat out, in order. The pipeline takes a new beat
// every cycle while it advances and passes it through, in order: fold, two
// CORDIC sine lanes (CORDIC_STAGES = 16), squares, sine sum, a 31-stage root
// for cos(alpha) and the axis length, a second 31-stage root for the half
// angle cos and sin, multiply, rounding bias, a 17-stage restoring divider
// for the axis parts (one quotient bit a stage) and the output register.
// The whole pipeline advances whenever the output register is empty or being
// taken; while a result beat waits, every stage holds, so bubbles in flight
// stay where they are.
// tilt_saturated in tuser marks a sum of squared sines of one or more (tilt
// clamped to pi/2); when both sines are zero x and y are zero and w is one.
// ----------------------------------------------------------------------------
module fused_pitch_roll_to_quaternion
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [15:0] roll_angle, [31:16] pitch_angle
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [15:0] quat_w, [31:16] quat_x, [47:32] quat_y
    output logic        m_tuser    // [0] tilt_saturated
);
    import fpq_pkg::*;

    logic en;
    assign en       = m_tready | ~m_tvalid;
    assign s_tready = en;

    // ---------------- fold + CORDIC ----------------
    logic               cv_reg [CORDIC_STAGES+1];
    logic signed [31:0] cx_reg [CORDIC_STAGES+1][2];
    logic signed [31:0] cy_reg [CORDIC_STAGES+1][2];
    logic signed [31:0] cz_reg [CORDIC_STAGES+1][2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= CORDIC_STAGES; i++)
                cv_reg[i] <= 1'b0;
        end
        else if (en)
        begin
            cv_reg[0] <= s_tvalid;
            for (int i = 1; i <= CORDIC_STAGES; i++)
                cv_reg[i] <= cv_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cx_reg[0][0] <= CORDIC_GAIN;
            cy_reg[0][0] <= '0;
            cz_reg[0][0] <= fold_angle(s_tdata[15:0]);
            cx_reg[0][1] <= CORDIC_GAIN;
            cy_reg[0][1] <= '0;
            cz_reg[0][1] <= fold_angle(s_tdata[31:16]);
        end
    end

    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
        for (genvar l = 0; l < 2; l++) begin : g_lane
            logic signed [31:0] dx;
            logic signed [31:0] dy;
            assign dx = cy_reg[i][l] >>> i;
            assign dy = cx_reg[i][l] >>> i;
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    if (!cz_reg[i][l][31])
                    begin
                        cx_reg[i+1][l] <= cx_reg[i][l] - dx;
                        cy_reg[i+1][l] <= cy_reg[i][l] + dy;
                        cz_reg[i+1][l] <= cz_reg[i][l] - atan_q29(i);
                    end
                    else
                    begin
                        cx_reg[i+1][l] <= cx_reg[i][l] + dx;
                        cy_reg[i+1][l] <= cy_reg[i][l] - dy;
                        cz_reg[i+1][l] <= cz_reg[i][l] + atan_q29(i);
                    end
                end
            end
        end
    end

    // ---------------- squares ----------------
    logic        sq_v_reg;
    logic [61:0] sq_reg [2];
    logic [30:0] mag_reg [2];
    logic        neg_reg [2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sq_v_reg <= 1'b0;
        else if (en)
            sq_v_reg <= cv_reg[CORDIC_STAGES];
    end

    for (genvar l = 0; l < 2; l++) begin : g_sq
        logic signed [31:0] s;
        logic [31:0]        a;
        assign s = cy_reg[CORDIC_STAGES][l];
        assign a = s[31] ? 32'(-s) : 32'(s);
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sq_reg[l]  <= 62'(a[30:0]) * 62'(a[30:0]);
                mag_reg[l] <= a[30:0];
                neg_reg[l] <= s[31];
            end
        end
    end

    // ---------------- sine sum ----------------
    logic        cr_v_reg;
    logic [61:0] argc_reg;
    logic [61:0] argr_reg;
    sb_t         cr_sb_reg;
    logic [62:0] crit;
    logic        sat;
    logic [30:0] cdiff;

    assign crit  = {1'b0, sq_reg[0]} + {1'b0, sq_reg[1]};
    assign sat   = |crit[62:58];
    assign cdiff = 31'h4000_0000 - {1'b0, crit[57:28]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cr_v_reg <= 1'b0;
        else if (en)
            cr_v_reg <= sq_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            argc_reg         <= sat ? 62'd0 : {1'b0, cdiff, 30'd0};
            argr_reg         <= crit[61:0];
            cr_sb_reg.mag_r  <= mag_reg[0];
            cr_sb_reg.mag_p  <= mag_reg[1];
            cr_sb_reg.neg_r  <= neg_reg[0];
            cr_sb_reg.neg_p  <= neg_reg[1];
            cr_sb_reg.sat    <= sat;
            cr_sb_reg.root_r <= '0;
            cr_sb_reg.w      <= '0;
        end
    end

    // ---------------- roots: cos(alpha) and axis length ----------------
    logic [30:0] c_root;
    logic [30:0] r_root;

    fpq_isqrt u_sqrt_c (.clk(clk), .en(en), .rad(argc_reg), .root(c_root));
    fpq_isqrt u_sqrt_r (.clk(clk), .en(en), .rad(argr_reg), .root(r_root));

    logic a_v_reg  [SQ_STAGES];
    sb_t  a_sb_reg [SQ_STAGES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SQ_STAGES; i++)
                a_v_reg[i] <= 1'b0;
        end
        else if (en)
        begin
            a_v_reg[0] <= cr_v_reg;
            for (int i = 1; i < SQ_STAGES; i++)
                a_v_reg[i] <= a_v_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_sb_reg[0] <= cr_sb_reg;
            for (int i = 1; i < SQ_STAGES; i++)
                a_sb_reg[i] <= a_sb_reg[i-1];
        end
    end

    // ---------------- roots: half-angle cos and sin ----------------
    logic [31:0] ch_sum;
    logic [31:0] sh_sum;
    logic [61:0] arg_ch;
    logic [61:0] arg_sh;
    logic [30:0] ch_root;
    logic [30:0] sh_root;
    sb_t         a_out_sb;

    assign ch_sum = (32'h4000_0000 + 32'(c_root)) >> 1;
    assign sh_sum = (32'h4000_0000 - 32'(c_root)) >> 1;
    assign arg_ch = {1'b0, ch_sum[30:0], 30'd0};
    assign arg_sh = {1'b0, sh_sum[30:0], 30'd0};

    always_comb
    begin
        a_out_sb        = a_sb_reg[SQ_STAGES-1];
        a_out_sb.root_r = r_root;
    end

    fpq_isqrt u_sqrt_ch (.clk(clk), .en(en), .rad(arg_ch), .root(ch_root));
    fpq_isqrt u_sqrt_sh (.clk(clk), .en(en), .rad(arg_sh), .root(sh_root));

    logic b_v_reg  [SQ_STAGES];
    sb_t  b_sb_reg [SQ_STAGES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SQ_STAGES; i++)
                b_v_reg[i] <= 1'b0;
        end
        else if (en)
        begin
            b_v_reg[0] <= a_v_reg[SQ_STAGES-1];
            for (int i = 1; i < SQ_STAGES; i++)
                b_v_reg[i] <= b_v_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_sb_reg[0] <= a_out_sb;
            for (int i = 1; i < SQ_STAGES; i++)
                b_sb_reg[i] <= b_sb_reg[i-1];
        end
    end

    // ---------------- multiply, w ----------------
    logic        mu_v_reg;
    logic [61:0] p_reg [2];
    sb_t         mu_sb_reg;
    sb_t         mu_sb_next;
    logic [31:0] w_sum;
    logic [15:0] w_val;

    assign w_sum = (32'(ch_root) + 32'h0000_8000) >> 16;
    assign w_val = (w_sum[15:0] > Q14_MAX) ? Q14_MAX : w_sum[15:0];

    always_comb
    begin
        mu_sb_next   = b_sb_reg[SQ_STAGES-1];
        mu_sb_next.w = w_val;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mu_v_reg <= 1'b0;
        else if (en)
            mu_v_reg <= b_v_reg[SQ_STAGES-1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg[0]  <= 62'(sh_root) * 62'(b_sb_reg[SQ_STAGES-1].mag_r);
            p_reg[1]  <= 62'(sh_root) * 62'(b_sb_reg[SQ_STAGES-1].mag_p);
            mu_sb_reg <= mu_sb_next;
        end
    end

    // ---------------- rounding bias: + d/2 ----------------
    logic        rb_v_reg;
    logic [63:0] rb_reg [2];
    sb_t         rb_sb_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rb_v_reg <= 1'b0;
        else if (en)
            rb_v_reg <= mu_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rb_reg[0] <= 64'(p_reg[0]) + (64'(mu_sb_reg.root_r) << 15);
            rb_reg[1] <= 64'(p_reg[1]) + (64'(mu_sb_reg.root_r) << 15);
            rb_sb_reg <= mu_sb_reg;
        end
    end

    // ---------------- restoring divide by r*2^16 ----------------
    logic                dv_v_reg  [DIV_BITS];
    sb_t                 dv_sb_reg [DIV_BITS];
    logic [63:0]         rem_reg   [DIV_BITS][2];
    logic [DIV_BITS-1:0] q_reg     [DIV_BITS][2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < DIV_BITS; j++)
                dv_v_reg[j] <= 1'b0;
        end
        else if (en)
        begin
            dv_v_reg[0] <= rb_v_reg;
            for (int j = 1; j < DIV_BITS; j++)
                dv_v_reg[j] <= dv_v_reg[j-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dv_sb_reg[0] <= rb_sb_reg;
            for (int j = 1; j < DIV_BITS; j++)
                dv_sb_reg[j] <= dv_sb_reg[j-1];
        end
    end

    for (genvar j = 0; j < DIV_BITS; j++) begin : g_div
        localparam int QB = DIV_BITS - 1 - j;
        for (genvar l = 0; l < 2; l++) begin : g_lane
            logic [63:0]         rem_in;
            logic [DIV_BITS-1:0] q_in;
            logic [30:0]         r_in;
            logic [63:0]         dsh;

            if (j == 0) begin : g_first
                assign rem_in = rb_reg[l];
                assign q_in   = '0;
                assign r_in   = rb_sb_reg.root_r;
            end else begin : g_rest
                assign rem_in = rem_reg[j-1][l];
                assign q_in   = q_reg[j-1][l];
                assign r_in   = dv_sb_reg[j-1].root_r;
            end

            assign dsh = 64'(r_in) << (16 + QB);

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    if (rem_in >= dsh)
                    begin
                        rem_reg[j][l] <= rem_in - dsh;
                        q_reg[j][l]   <= q_in | (DIV_BITS'(1) << QB);
                    end
                    else
                    begin
                        rem_reg[j][l] <= rem_in;
                        q_reg[j][l]   <= q_in;
                    end
                end
            end
        end
    end

    // ---------------- clamp, sign, output register ----------------
    logic [15:0] qc   [2];
    logic [15:0] part [2];
    sb_t         fin_sb;

    assign fin_sb = dv_sb_reg[DIV_BITS-1];

    always_comb
    begin
        for (int l = 0; l < 2; l++)
        begin
            if (q_reg[DIV_BITS-1][l] > DIV_BITS'(Q14_MAX))
                qc[l] = Q14_MAX;
            else
                qc[l] = q_reg[DIV_BITS-1][l][15:0];
        end
        if (fin_sb.root_r == '0)
        begin
            part[0] = '0;
            part[1] = '0;
        end
        else
        begin
            part[0] = fin_sb.neg_r ? 16'(-qc[0]) : qc[0];
            part[1] = fin_sb.neg_p ? 16'(-qc[1]) : qc[1];
        end
    end

    logic        out_v_reg;
    logic [47:0] out_data_reg;
    logic        out_user_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_v_reg <= 1'b0;
        else if (en)
            out_v_reg <= dv_v_reg[DIV_BITS-1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_data_reg <= {part[1], part[0], fin_sb.w};
            out_user_reg <= fin_sb.sat;
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

endmodule

### hdl/fpq_checker.sv
// ----------------------------------------------------------------------------
// fpq_checker
// Port-level checks for the tilt quaternion block, bound to the top level.
// ----------------------------------------------------------------------------
`include "fused_pitch_roll_to_quaternion_defines.svh"

module fpq_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [31:0] s_tdata,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic        m_tuser
);
    // stalled result beat holds
    `FPQ_ASSERT_NXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

    // w is a non-negative Q1.14 value no larger than one
    `FPQ_ASSERT_IMP(a_w_range, clk, rst_n, m_tvalid, m_tdata[15:0] <= 16'd16384)

    // clamped tilt gives w = sqrt(1/2)
    `FPQ_ASSERT_IMP(a_sat_w, clk, rst_n, m_tvalid && m_tuser, m_tdata[15:0] == 16'd11585)

    // empty output register never holds off the input side
    `FPQ_ASSERT_IMP(a_ready, clk, rst_n, !m_tvalid, s_tready)

endmodule

bind fused_pitch_roll_to_quaternion fpq_checker u_fpq_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

### verif/tb_fused_pitch_roll_to_quaternion.sv
// ----------------------------------------------------------------------------
// tb_fused_pitch_roll_to_quaternion
// Drives roll/pitch beats into the tilt quaternion pipeline and checks every
// result beat against a bit-exact fixed-point predictor kept in this bench.
// ----------------------------------------------------------------------------
module tb_fused_pitch_roll_to_quaternion;
    import fpq_pkg::*;

    localparam int LATENCY   = 101;
    localparam int WDOG_MAX  = 20000;
    localparam longint ANGPI = 64'sd1686629713;
    localparam longint ANGHP = 64'sd843314857;
    localparam longint GAIN0 = 64'sd326016437;

    typedef struct packed {
        logic [15:0] w;
        logic [15:0] x;
        logic [15:0] y;
        logic        sat;
    } tilt_quat_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;   // [15:0] roll_angle, [31:16] pitch_angle
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;   // [15:0] quat_w, [31:16] quat_x, [47:32] quat_y
    logic        m_tuser;   // [0] tilt_saturated

    tilt_quat_t quat_fifo[$];
    int  n_errors    = 0;
    int  n_sent      = 0;
    int  n_checked   = 0;
    int  n_sat       = 0;
    int  n_zero_axis = 0;
    int  idle_cycles = 0;
    bit  rx_hold     = 0;   // forces a long receiver stall

    fused_pitch_roll_to_quaternion i_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // ---------------- predictor ----------------
    function automatic longint shr_floor(input longint v, input int s);
        return v >>> s;   // arithmetic shift on signed longint: floor
    endfunction

    function automatic longint unsigned floor_root(input longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint angle_to_q29(input logic [15:0] raw);
        longint a;
        a = longint'($signed(raw)) * 65536;
        if (a > ANGHP)
            a = ANGPI - a;
        else if (a < -ANGHP)
            a = -ANGPI - a;
        return a;
    endfunction

    function automatic longint sine_q29(input longint z);
        longint cx;
        longint cy;
        longint dx;
        longint dy;
        longint t;
        cx = GAIN0;
        cy = 0;
        for (int i = 0; i < CORDIC_STAGES && i < 24; i++)
        begin
            dx = shr_floor(cy, i);
            dy = shr_floor(cx, i);
            t  = longint'(atan_q29(i));
            if (z >= 0)
            begin
                cx = cx - dx; cy = cy + dy; z = z - t;
            end
            else
            begin
                cx = cx + dx; cy = cy - dy; z = z + t;
            end
        end
        return cy;
    endfunction

    function automatic logic [15:0] axis_comp(input longint unsigned sh, input longint s,
                                              input longint unsigned r);
        longint unsigned mag;
        longint unsigned d;
        longint unsigned q;
        mag = (s < 0) ? longint'(-s) : s;
        d   = r << 16;
        q   = (sh * mag + d / 2) / d;
        if (q > 16384)
            q = 16384;
        return (s < 0) ? 16'(-longint'(q)) : 16'(q);
    endfunction

    function automatic tilt_quat_t predict_tilt(input logic [15:0] roll, input logic [15:0] pitch);
        tilt_quat_t q;
        longint sr;
        longint sp;
        longint unsigned ar;
        longint unsigned ap;
        longint unsigned crit;
        longint unsigned c;
        longint unsigned ch;
        longint unsigned sh;
        longint unsigned r;
        longint unsigned w;
        sr   = sine_q29(angle_to_q29(roll));
        sp   = sine_q29(angle_to_q29(pitch));
        ar   = (sr < 0) ? -sr : sr;
        ap   = (sp < 0) ? -sp : sp;
        crit = ar * ar + ap * ap;
        q.sat = (crit >= (64'd1 << 58));
        c = 0;
        if (!q.sat)
            c = floor_root(((64'd1 << 30) - (crit >> 28)) << 30);
        ch = floor_root((((64'd1 << 30) + c) >> 1) << 30);
        sh = floor_root((((64'd1 << 30) - c) >> 1) << 30);
        r  = floor_root(crit);
        q.x = '0;
        q.y = '0;
        if (r != 0)
        begin
            q.x = axis_comp(sh, sr, r);
            q.y = axis_comp(sh, sp, r);
        end
        w = (ch + (64'd1 << 15)) >> 16;
        if (w > 16384)
            w = 16384;
        q.w = w[15:0];
        return q;
    endfunction

    // ---------------- sender ----------------
    task automatic send_angles(input logic [15:0] roll, input logic [15:0] pitch);
        tilt_quat_t q;
        q = predict_tilt(roll, pitch);
        s_tvalid <= 1'b1;
        s_tdata  <= {pitch, roll};
        do
            @(posedge clk);
        while (!s_tready);
        quat_fifo.push_back(q);
        n_sent++;
        if (q.sat)
            n_sat++;
        if (q.x == 0 && q.y == 0 && !q.sat)
            n_zero_axis++;
    endtask

    // random gap: mostly none or short, sometimes long
    task automatic sender_gap();
        int g;
        case ($urandom_range(0, 9))
            0, 1, 2: g = $urandom_range(1, 3);
            3:       g = $urandom_range(10, 40);
            default: g = 0;
        endcase
        if (g != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        while (quat_fifo.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [15:0] rand_angle();
        case ($urandom_range(0, 5))
            0:       return 16'($urandom_range(0, 65535) & 16'h00FF);   // near zero
            1:       return 16'(16'sd12868 + $signed(16'($urandom_range(0, 40))) - 16'sd20);
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    // ---------------- tests ----------------
    task automatic test_directed();
        logic [15:0] corner[10];
        corner = '{16'h0000, 16'h7FFF, 16'h8000, 16'h0001, 16'hFFFF,
                   16'd12868, 16'd12869, -16'sd12868, 16'd25736, 16'h5555};
        send_angles(16'h0000, 16'h0000);      // both sines zero: x and y zero, w one
        send_angles(16'd12868, 16'd12868);    // sine sum above one: saturated tilt
        send_angles(16'd12868, 16'h0000);     // pure roll near pi/2
        send_angles(16'h0000, -16'sd12868);   // pure pitch, negative
        send_angles(16'd25736, 16'h0000);     // roll near pi: folds back to near zero
        send_angles(16'h7FFF, 16'h8000);      // field extremes, large angle fold
        send_angles(16'h8000, 16'h7FFF);
        send_angles(16'hFFFF, 16'h0001);
        for (int i = 0; i < 15; i++)
            send_angles(corner[$urandom_range(0, 9)], corner[$urandom_range(0, 9)]);
        s_tvalid <= 1'b0;
        wait_drained();
    endtask

    task automatic test_random_stream(input int n);
        for (int i = 0; i < n; i++)
        begin
            send_angles(rand_angle(), rand_angle());
            sender_gap();
        end
    endtask

    // receiver holds off while the sender keeps offering, so the pipe fills
    task automatic test_backpressure();
        rx_hold <= 1'b1;
        fork
            test_random_stream(160);
            begin
                repeat (300) @(posedge clk);
                rx_hold <= 1'b0;
            end
        join
        s_tvalid <= 1'b0;
        wait_drained();   // sender pauses until every result is back
    endtask

    // ---------------- receiver and checker ----------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (rx_hold)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(0, 9) < 7) || ($urandom_range(0, 49) == 0);
    end

    always @(posedge clk)
    begin
        tilt_quat_t exp_q;
        tilt_quat_t got_q;
        if (rst_n && m_tvalid && m_tready)
        begin
            got_q = '{w: m_tdata[15:0], x: m_tdata[31:16], y: m_tdata[47:32], sat: m_tuser};
            if (quat_fifo.size() == 0)
            begin
                $display("%0t: unexpected result beat %h/%b", $time, m_tdata, m_tuser);
                n_errors++;
            end
            else
            begin
                exp_q = quat_fifo.pop_front();
                n_checked++;
                if (got_q.w !== exp_q.w)
                begin
                    $display("%0t: quat_w exp %h got %h", $time, exp_q.w, got_q.w);
                    n_errors++;
                end
                if (got_q.x !== exp_q.x)
                begin
                    $display("%0t: quat_x exp %h got %h", $time, exp_q.x, got_q.x);
                    n_errors++;
                end
                if (got_q.y !== exp_q.y)
                begin
                    $display("%0t: quat_y exp %h got %h", $time, exp_q.y, got_q.y);
                    n_errors++;
                end
                if (got_q.sat !== exp_q.sat)
                begin
                    $display("%0t: tilt_saturated exp %b got %b", $time, exp_q.sat, got_q.sat);
                    n_errors++;
                end
            end
        end
    end

    // watchdog: cycles with no beat accepted on either side
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_MAX)
        begin
            $display("%0t: timeout, %0d results outstanding", $time, quat_fifo.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ---------------- sequence ----------------
    initial
    begin
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random_stream(200);
        test_backpressure();
        test_random_stream(170);
        s_tvalid <= 1'b0;
        wait_drained();
        repeat (LATENCY + 20) @(posedge clk);
        $display("Sent %0d angle pairs, checked %0d quaternions (%0d saturated, %0d zero axis).",
                 n_sent, n_checked, n_sat, n_zero_axis);
        $display("Covered field extremes, angle folding, long output stall and random gaps.");
        if (n_errors == 0 && quat_fifo.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

### filelist.f
+incdir+hdl
hdl/fpq_pkg.sv
hdl/fpq_isqrt.sv
hdl/fused_pitch_roll_to_quaternion.sv
hdl/fpq_checker.sv
verif/tb_fused_pitch_roll_to_quaternion.sv
